@@ rtl/prsa_pkg.sv @@
// Package: shared types, constants and binary16 arithmetic for the rotation core.
`default_nettype none
package prsa_pkg;

  localparam int MaxRows = 16;
  localparam int MaxCols = 16;
  localparam int RotDepth = 15;
  localparam int AddrW = 8;
  localparam int RotW = 4;

  typedef enum logic [1:0] {
    CMD_WRITE_ELEM = 2'd0,
    CMD_WRITE_PAIR = 2'd1,
    CMD_APPLY      = 2'd2,
    CMD_READ_ELEM  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    REG_SIDE  = 3'd0,
    REG_PIVOT = 3'd1,
    REG_DIR   = 3'd2,
    REG_ROWS  = 3'd3,
    REG_COLS  = 3'd4
  } reg_idx_t;

  localparam logic [1:0] PIVOT_VAR = 2'd0;
  localparam logic [1:0] PIVOT_TOP = 2'd1;
  localparam logic [1:0] PIVOT_BOT = 2'd2;
  localparam logic [1:0] PIVOT_BAD = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RESP,
    ST_PAIR,
    ST_PAIR_WAIT,
    ST_LD,
    ST_LD_WAIT,
    ST_MUL,
    ST_ADD,
    ST_WR_HI,
    ST_WR_LO,
    ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic [RotW-1:0]  pair_addr;
    logic             pair_latch;
    logic             mem_rd;
    logic [AddrW-1:0] mem_addr;
    logic             latch_hi;
    logic             latch_lo;
    logic             do_mul;
    logic             do_add;
    logic             wr_hi;
    logic             wr_lo;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic skip_pair;
  } sts_t;

  // Round a nonnegative magnitude given as value = sig * 2^(exp-25),
  // sig up to 26 bits with a sticky bit below, to binary16 with nearest-even.
  function automatic logic [15:0] h_pack(input logic sign, input logic signed [7:0] exp_in,
                                         input logic [25:0] sig_in, input logic sticky_in);
    logic [25:0] s;
    logic signed [7:0] e;
    logic st;
    logic [11:0] q;
    logic rb, sb;
    logic [5:0] sh;
    logic [38:0] wide;
    logic [15:0] r;
    s = sig_in;
    e = exp_in;
    st = sticky_in;
    r = {sign, 15'd0};
    if (s != 26'd0) begin
      // Normalize: leading one to bit 25.
      for (int i = 0; i < 5; i++) begin
        if (s[25:10] == 16'd0 && i == 0) begin s = s << 16; e = e - 8'sd16; end
        if (s[25:18] == 8'd0 && i == 1) begin s = s << 8; e = e - 8'sd8; end
        if (s[25:22] == 4'd0 && i == 2) begin s = s << 4; e = e - 8'sd4; end
        if (s[25:24] == 2'd0 && i == 3) begin s = s << 2; e = e - 8'sd2; end
        if (s[25] == 1'b0 && i == 4) begin s = s << 1; e = e - 8'sd1; end
      end
      // Value = 1.f * 2^e. Keep 11 bits when normal; shift more when subnormal.
      if (e > 8'sd15) begin
        r = {sign, 15'h7C00};
      end else begin
        if (e >= -8'sd14) sh = 6'd15;
        else if (e < -8'sd40) sh = 6'd38;
        else sh = 6'(8'sd1 - e);
        wide = {s, 13'd0} >> sh;
        q = {1'b0, wide[23:13]};
        rb = wide[12];
        sb = (wide[11:0] != 12'd0) || st || ((({s, 13'd0} << (6'd39 - sh)) != 39'd0) && sh != 6'd0);
        if (rb && (sb || q[0])) q = q + 12'd1;
        if (e >= -8'sd14) begin
          if (q[11]) begin
            q = 12'h400;
            e = e + 8'sd1;
          end
          if (e > 8'sd15) r = {sign, 15'h7C00};
          else r = {sign, 5'(e + 8'sd15), q[9:0]};
        end else begin
          r = {sign, q[10:0] == 11'h400 ? 5'd1 : 5'd0, q[9:0]};
        end
      end
    end
    return r;
  endfunction

  function automatic logic h_nan(input logic [15:0] a);
    return a[14:10] == 5'd31 && a[9:0] != 10'd0;
  endfunction

  function automatic logic h_inf(input logic [15:0] a);
    return a[14:10] == 5'd31 && a[9:0] == 10'd0;
  endfunction

  // binary16 product, rounded nearest-even.
  function automatic logic [15:0] h_mul(input logic [15:0] a, input logic [15:0] b);
    logic sg;
    logic [10:0] ma, mb;
    logic signed [7:0] ea, eb;
    logic [21:0] p;
    logic [15:0] r;
    sg = a[15] ^ b[15];
    if (h_nan(a) || h_nan(b)) r = 16'h7E00;
    else if (h_inf(a) || h_inf(b)) begin
      if ((a[14:0] == 15'd0) || (b[14:0] == 15'd0)) r = 16'h7E00;
      else r = {sg, 15'h7C00};
    end else begin
      ma = {a[14:10] != 5'd0, a[9:0]};
      mb = {b[14:10] != 5'd0, b[9:0]};
      ea = (a[14:10] == 5'd0) ? -8'sd14 : 8'(a[14:10]) - 8'sd15;
      eb = (b[14:10] == 5'd0) ? -8'sd14 : 8'(b[14:10]) - 8'sd15;
      p = ma * mb;
      // value = p * 2^(ea+eb-20) = {p,4'b0} * 2^(ea+eb+1-25)
      r = h_pack(sg, ea + eb + 8'sd1, {p, 4'd0}, 1'b0);
    end
    return r;
  endfunction

  // binary16 sum, rounded nearest-even; zero sign by round-to-nearest rules.
  function automatic logic [15:0] h_add(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] x, y, r;
    logic signed [7:0] ex, ey;
    logic [4:0] d;
    logic [25:0] mx, my, ys, sum;
    logic st;
    if (h_nan(a) || h_nan(b)) r = 16'h7E00;
    else if (h_inf(a) && h_inf(b)) r = (a[15] == b[15]) ? a : 16'h7E00;
    else if (h_inf(a)) r = a;
    else if (h_inf(b)) r = b;
    else begin
      if (a[14:0] >= b[14:0]) begin x = a; y = b; end
      else begin x = b; y = a; end
      ex = (x[14:10] == 5'd0) ? -8'sd14 : 8'(x[14:10]) - 8'sd15;
      ey = (y[14:10] == 5'd0) ? -8'sd14 : 8'(y[14:10]) - 8'sd15;
      mx = {2'd0, x[14:10] != 5'd0, x[9:0], 13'd0};
      my = {2'd0, y[14:10] != 5'd0, y[9:0], 13'd0};
      d = (ex - ey > 8'sd24) ? 5'd24 : 5'(ex - ey);
      ys = my >> d;
      st = ((ys << d) != my);
      if (x[15] == y[15]) sum = mx + ys;
      else sum = mx - ys - {25'd0, st};
      // mx aligned so that value = mx * 2^(ex-23) = sum * 2^((ex+2)-25)
      if (sum == 26'd0 && !st) r = {x[15] & y[15], 15'd0};
      else r = h_pack(x[15], ex + 8'sd2, sum, st);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

@@ rtl/prsa_ram.sv @@
// Generic RAM with one write port and one registered read port.
`default_nettype none
module prsa_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/prsa_datapath.sv @@
// Datapath: matrix and pair memories, operand registers and binary16 arithmetic.
`default_nettype none
module prsa_datapath (
  input  wire logic                      clk,
  input  wire prsa_pkg::ctl_t            ctl,
  input  wire logic                      host_elem_we,
  input  wire logic [prsa_pkg::AddrW-1:0] host_addr,
  input  wire logic [15:0]               host_elem,
  input  wire logic                      host_pair_we,
  input  wire logic [prsa_pkg::RotW-1:0] host_pair_addr,
  input  wire logic [15:0]               host_cos,
  input  wire logic [15:0]               host_sin,
  output logic [15:0]                    mem_q,
  output prsa_pkg::sts_t                 sts
);
  import prsa_pkg::*;

  logic [15:0] cos_q, sin_q, c_r, s_r, x_r, y_r;
  logic [15:0] cx, sy, sx, cy, new_hi, new_lo;
  logic        m_we;
  logic [AddrW-1:0] m_addr;
  logic [15:0] m_wdata;

  // Matrix write port is shared by host writes and write-back.
  always_comb begin
    m_we = host_elem_we || ctl.wr_hi || ctl.wr_lo;
    m_wdata = ctl.wr_hi ? new_hi : (ctl.wr_lo ? new_lo : host_elem);
    m_addr = (ctl.wr_hi || ctl.wr_lo) ? ctl.mem_addr : host_addr;
  end

  prsa_ram #(.Width(16), .Depth(MaxRows * MaxCols)) u_mat (
    .clk, .we(m_we), .waddr(m_addr), .wdata(m_wdata),
    .raddr(ctl.mem_rd ? ctl.mem_addr : host_addr), .rdata(mem_q)
  );
  prsa_ram #(.Width(16), .Depth(16)) u_cos (
    .clk, .we(host_pair_we), .waddr(host_pair_addr), .wdata(host_cos),
    .raddr(ctl.pair_addr), .rdata(cos_q)
  );
  prsa_ram #(.Width(16), .Depth(16)) u_sin (
    .clk, .we(host_pair_we), .waddr(host_pair_addr), .wdata(host_sin),
    .raddr(ctl.pair_addr), .rdata(sin_q)
  );

  // Operand, product and result registers.
  always_ff @(posedge clk) begin
    if (ctl.pair_latch) begin c_r <= cos_q; s_r <= sin_q; end
    if (ctl.latch_hi) x_r <= mem_q;
    if (ctl.latch_lo) y_r <= mem_q;
    if (ctl.do_mul) begin
      cx <= h_mul(c_r, x_r);
      sy <= h_mul(s_r, y_r);
      sx <= h_mul(s_r, x_r);
      cy <= h_mul(c_r, y_r);
    end
    if (ctl.do_add) begin
      new_hi <= h_add(cx, {~sy[15], sy[14:0]});
      new_lo <= h_add(sx, cy);
    end
  end

  assign sts.skip_pair = (c_r == 16'h3C00) && (s_r[14:0] == 15'd0);
endmodule
`default_nettype wire

@@ rtl/prsa_ctrl.sv @@
// Controller: command decode and the walk over rotations and positions.
`default_nettype none
module prsa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           start,
  input  wire logic [1:0]     command,
  input  wire logic           rotate_side,
  input  wire logic [1:0]     pivot_mode,
  input  wire logic           walk_direction,
  input  wire logic [4:0]     row_count,
  input  wire logic [4:0]     col_count,
  input  wire prsa_pkg::sts_t sts,
  output prsa_pkg::ctl_t      ctl,
  output logic                busy,
  output logic                done,
  output logic                rd_sel,
  output logic                status
);
  import prsa_pkg::*;

  state_t state, state_next;
  logic [4:0] lines, lines_next, span, span_next;
  logic [3:0] t, t_next, p, p_next;
  logic       is_read, is_read_next, st_bad, st_bad_next;
  logic [4:0] rows_s, cols_s;
  logic [3:0] k, lo, hi;
  logic [AddrW-1:0] a_lo, a_hi;

  always_comb begin
    rows_s = (row_count > 5'(MaxRows)) ? 5'(MaxRows) : row_count;
    cols_s = (col_count > 5'(MaxCols)) ? 5'(MaxCols) : col_count;
    k = walk_direction ? 4'(lines - 5'd2 - {1'b0, t}) : t;
    unique case (pivot_mode)
      PIVOT_TOP: begin lo = 4'd0; hi = k + 4'd1; end
      PIVOT_BOT: begin lo = k; hi = 4'(lines - 5'd1); end
      default:   begin lo = k; hi = k + 4'd1; end
    endcase
    a_lo = rotate_side ? {lo, p} : {p, lo};
    a_hi = rotate_side ? {hi, p} : {p, hi};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      is_read <= 1'b0;
      st_bad <= 1'b0;
    end else begin
      state <= state_next;
      is_read <= is_read_next;
      st_bad <= st_bad_next;
    end
    lines <= lines_next;
    span <= span_next;
    t <= t_next;
    p <= p_next;
  end

  always_comb begin
    state_next = state;
    lines_next = lines;
    span_next = span;
    t_next = t;
    p_next = p;
    is_read_next = is_read;
    st_bad_next = st_bad;
    ctl = '0;
    ctl.pair_addr = k;
    ctl.mem_addr = a_hi;
    busy = (state != ST_IDLE);
    done = 1'b0;
    rd_sel = is_read;
    status = st_bad;
    unique case (state)
      ST_IDLE: begin
        ctl.mem_rd = 1'b0;
        if (start) begin
          is_read_next = (command == CMD_READ_ELEM);
          st_bad_next = 1'b0;
          lines_next = rotate_side ? cols_s : rows_s;
          span_next = rotate_side ? rows_s : cols_s;
          t_next = 4'd0;
          p_next = 4'd0;
          if (command == CMD_APPLY) begin
            if (pivot_mode == PIVOT_BAD) begin
              st_bad_next = 1'b1;
              state_next = ST_RESP;
            end else if (rows_s == 5'd0 || cols_s == 5'd0
                         || (rotate_side ? cols_s : rows_s) < 5'd2) begin
              state_next = ST_RESP;
            end else begin
              state_next = ST_PAIR;
            end
          end else begin
            state_next = ST_RESP;
          end
        end
      end
      ST_RESP: begin
        done = 1'b1;
        state_next = ST_IDLE;
      end
      ST_PAIR: begin
        state_next = ST_PAIR_WAIT;
      end
      ST_PAIR_WAIT: begin
        ctl.pair_latch = 1'b1;
        p_next = 4'd0;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (sts.skip_pair) begin
          state_next = ST_DONE;
        end else begin
          ctl.mem_rd = 1'b1;
          ctl.mem_addr = a_hi;
          state_next = ST_LD_WAIT;
        end
      end
      ST_LD_WAIT: begin
        ctl.mem_rd = 1'b1;
        ctl.mem_addr = a_lo;
        ctl.latch_hi = 1'b1;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        ctl.latch_lo = 1'b1;
        state_next = ST_ADD;
      end
      ST_ADD: begin
        ctl.do_mul = 1'b1;
        state_next = ST_WR_HI;
      end
      ST_WR_HI: begin
        ctl.do_add = 1'b1;
        state_next = ST_WR_LO;
      end
      ST_WR_LO: begin
        ctl.wr_hi = 1'b1;
        ctl.mem_addr = a_hi;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!sts.skip_pair) begin
          ctl.wr_lo = 1'b1;
          ctl.mem_addr = a_lo;
        end
        if (!sts.skip_pair && ({1'b0, p} + 5'd1 < span)) begin
          p_next = p + 4'd1;
          state_next = ST_LD;
        end else if ({1'b0, t} + 5'd2 < lines) begin
          t_next = t + 4'd1;
          state_next = ST_PAIR;
        end else begin
          state_next = ST_RESP;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/plane_rotation_sequence_apply_core.sv @@
// Top level: configuration registers, controller and datapath.
// Write element, write pair, read, refused or empty apply: the result beat comes in the cycle
// after the accepting edge and busy is high in it, so the next command waits for that beat.
// Apply over L lines of S positions: each of the L-1 pairs fetches cosine and sine, then
// updates its S positions (none for an identity pair); the result beat follows the last pair.
// The receiver cannot stall; one command at a time, busy is high until the result strobe.
// Synchronous reset clears configuration and FSM state; memories are undefined until written.
`default_nettype none
module plane_rotation_sequence_apply_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  command,
  input  wire logic [3:0]  row_index,
  input  wire logic [3:0]  col_index,
  input  wire logic [3:0]  rotation_index,
  input  wire logic [15:0] element_value,
  input  wire logic [15:0] cosine_value,
  input  wire logic [15:0] sine_value,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [4:0]  cfg_data,
  output logic             result_valid,
  output logic [15:0]      read_value,
  output logic             status
);
  import prsa_pkg::*;

  logic rotate_side, walk_direction;
  logic [1:0] pivot_mode;
  logic [4:0] row_count, col_count;
  ctl_t ctl;
  sts_t sts;
  logic [15:0] mem_q;
  logic done, rd_sel, st_bad, acc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_side <= 1'b0;
      pivot_mode <= 2'd0;
      walk_direction <= 1'b0;
      row_count <= 5'd0;
      col_count <= 5'd0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_SIDE:  rotate_side <= cfg_data[0];
        REG_PIVOT: pivot_mode <= cfg_data[1:0];
        REG_DIR:   walk_direction <= cfg_data[0];
        REG_ROWS:  row_count <= cfg_data;
        REG_COLS:  col_count <= cfg_data;
        default: ;
      endcase
    end
  end

  assign acc = start && !busy;

  prsa_ctrl u_ctrl (
    .clk, .rst, .start(acc), .command,
    .rotate_side, .pivot_mode, .walk_direction, .row_count, .col_count,
    .sts, .ctl, .busy, .done, .rd_sel, .status(st_bad)
  );

  prsa_datapath u_dp (
    .clk, .ctl,
    .host_elem_we(acc && command == CMD_WRITE_ELEM),
    .host_addr({col_index, row_index}),
    .host_elem(element_value),
    .host_pair_we(acc && command == CMD_WRITE_PAIR && rotation_index < 4'(RotDepth)),
    .host_pair_addr(rotation_index),
    .host_cos(cosine_value),
    .host_sin(sine_value),
    .mem_q, .sts
  );

  // Result beat.
  assign result_valid = done;
  assign read_value = (done && rd_sel) ? mem_q : 16'd0;
  assign status = done && st_bad;
endmodule
`default_nettype wire
